### rtl/state_space_model_step_top_assert.svh
// Assertion macros for the state-space model block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef STATE_SPACE_MODEL_STEP_TOP_ASSERT_SVH
`define STATE_SPACE_MODEL_STEP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("state_space_model_step_top: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("state_space_model_step_top: next-cycle check failed");

`endif

### rtl/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

    localparam int DATA_W     = 32;
    localparam int MAX_STATES = 4;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CNT_W    = $clog2(MAX_STATES + 1);
    localparam int CA_DEPTH = MAX_STATES * MAX_STATES + 2 * MAX_STATES;
    localparam int CA_W     = $clog2(CA_DEPTH);
    localparam int B_BASE   = MAX_STATES * MAX_STATES;
    localparam int C_BASE   = MAX_STATES * MAX_STATES + MAX_STATES;
    localparam int ACC_W    = 2 * DATA_W - FRAC_BITS + $clog2(MAX_STATES + 2);

    localparam int CFG_W       = 3;
    localparam int CFG_N_RESET = 2;
    localparam int APB_AW      = 3;
    localparam logic REG_STATES_IN_USE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CWRITE,
        ST_ISSUE,
        ST_DRAIN,
        ST_WRITEBACK,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_STEP,
        OP_COPY,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        CMD_STEP = 2'd0,
        CMD_SET  = 2'd1,
        CMD_COPY = 2'd2,
        CMD_COEF = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_A = 2'd0,
        KIND_B = 2'd1,
        KIND_C = 2'd2
    } kind_t;

    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [IDX_W-1:0] row;
        logic             first;
        logic             last;
        logic             use_u;
    } tag_t;

    typedef struct packed {
        logic              clip;
        logic [DATA_W-1:0] val;
    } sat_t;

    function automatic sat_t saturate(input logic signed [ACC_W-1:0] v);
        sat_t                      r;
        logic [ACC_W-DATA_W:0]     top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || !(|top))
        begin
            r.clip = 1'b0;
            r.val  = v[DATA_W-1:0];
        end
        else
        begin
            r.clip = 1'b1;
            r.val  = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/state_space_model_step_top.sv
`timescale 1ns / 1ps
// Channel      Direction  Beat contents
// s_axis       in         tuser: cmd, coef_kind; tdata: value, row_index, col_index
// m_axis       out        tuser: saturated; tdata: y
// APB          in/out     register 0 at byte address 0: states_in_use
// A step or a copy of B runs issue, drain and write-back, then an output pass of issue and drain.
// A set-state item begins at write-back, a coefficient write at the write; then the output pass.
// One shared multiplier and accumulator serve every product; the memory read port sets the pace.
// Reset clears the state to zero through per-entry valid bits; no clearing pass is needed.
// A new beat is accepted while the previous result still waits in the output register.

module state_space_model_step_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [39:0]                s_axis_tdata,   // value[31:0], row_index[33:32], col_index[35:34]
    input  logic [3:0]                 s_axis_tuser,   // cmd[1:0], coef_kind[3:2]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,   // y[31:0]
    output logic                       m_axis_tuser,   // saturated
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ssm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int DW = ssm_pkg::DATA_W;
    localparam int IW = ssm_pkg::IDX_W;
    localparam int CW = ssm_pkg::CNT_W;
    localparam int AW = ssm_pkg::CA_W;

    ssm_pkg::state_t state_reg, state_next;
    ssm_pkg::op_t    op_reg;

    logic [ssm_pkg::CFG_W-1:0] cfg_n_reg;
    logic [CW-1:0]             n_reg;
    logic [CW-1:0]             n_clamp;
    logic [CW-1:0]             i_reg;
    logic [CW-1:0]             j_reg;
    logic [IW-1:0]             i_idx;
    logic [IW-1:0]             j_idx;

    logic [DW-1:0] value_reg;
    logic [1:0]    kind_reg;
    logic [1:0]    row_reg;
    logic [1:0]    col_reg;

    logic [DW-1:0] coef_mem [ssm_pkg::CA_DEPTH];
    logic [DW-1:0] coef_q_reg;
    logic [AW-1:0] coef_raddr;
    logic [AW-1:0] coef_waddr;
    logic          coef_we;

    logic [DW-1:0]                 x_mem [ssm_pkg::MAX_STATES];
    logic [ssm_pkg::MAX_STATES-1:0] x_valid_reg;
    logic [DW-1:0]                 x_q_reg;
    logic                          x_qv_reg;
    logic [IW-1:0]                 x_raddr;
    logic                          x_we;
    logic [DW-1:0]                 x_rd;

    logic [DW-1:0] next_x_reg [ssm_pkg::MAX_STATES];

    ssm_pkg::tag_t tag0, tag1_reg, tag2_reg;
    ssm_pkg::tag_t tag1_mac;
    logic          issue_done;
    logic          pipe_empty;
    logic          in_accept;
    logic          out_load;
    logic          wb_done;
    logic          mac_window;

    logic signed [DW-1:0]            mul_a;
    logic signed [DW-1:0]            mul_b;
    logic signed [2*DW-1:0]          prod_reg;
    logic signed [ssm_pkg::ACC_W-1:0] term;
    logic signed [ssm_pkg::ACC_W-1:0] acc_sum;
    logic signed [ssm_pkg::ACC_W-1:0] acc_reg;
    ssm_pkg::sat_t                   sat_res;

    logic          flag_reg;
    logic [DW-1:0] y_res_reg;
    logic          out_valid_reg;
    logic [DW-1:0] y_out_reg;
    logic          sat_out_reg;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ssm_pkg::REG_STATES_IN_USE) ? 32'(cfg_n_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_n_reg <= ssm_pkg::CFG_W'(ssm_pkg::CFG_N_RESET);
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == ssm_pkg::REG_STATES_IN_USE))
        begin
            cfg_n_reg <= pwdata[ssm_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (cfg_n_reg == '0)
        begin
            n_clamp = CW'(1);
        end
        else if (int'(cfg_n_reg) > ssm_pkg::MAX_STATES)
        begin
            n_clamp = CW'(ssm_pkg::MAX_STATES);
        end
        else
        begin
            n_clamp = CW'(cfg_n_reg);
        end
    end

    assign s_axis_tready = (state_reg == ssm_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign pipe_empty    = !tag1_reg.valid && !tag2_reg.valid;
    assign out_load      = (state_reg == ssm_pkg::ST_FINISH) && (!out_valid_reg || m_axis_tready);
    assign i_idx         = i_reg[IW-1:0];
    assign j_idx         = j_reg[IW-1:0];
    assign wb_done       = (i_reg == n_reg - CW'(1));
    assign mac_window    = (state_reg == ssm_pkg::ST_ISSUE) || (state_reg == ssm_pkg::ST_DRAIN);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (ssm_pkg::cmd_t'(s_axis_tuser[1:0]))
                        ssm_pkg::CMD_STEP: state_next = ssm_pkg::ST_ISSUE;
                        ssm_pkg::CMD_SET:  state_next = ssm_pkg::ST_WRITEBACK;
                        ssm_pkg::CMD_COPY: state_next = ssm_pkg::ST_ISSUE;
                        ssm_pkg::CMD_COEF: state_next = ssm_pkg::ST_CWRITE;
                        default:           state_next = ssm_pkg::ST_IDLE;
                    endcase
                end
            end
            ssm_pkg::ST_CWRITE:    state_next = ssm_pkg::ST_ISSUE;
            ssm_pkg::ST_ISSUE:
            begin
                if (issue_done)
                begin
                    state_next = ssm_pkg::ST_DRAIN;
                end
            end
            ssm_pkg::ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = (op_reg == ssm_pkg::OP_OUT) ? ssm_pkg::ST_FINISH
                                                             : ssm_pkg::ST_WRITEBACK;
                end
            end
            ssm_pkg::ST_WRITEBACK:
            begin
                if (wb_done)
                begin
                    state_next = ssm_pkg::ST_ISSUE;
                end
            end
            ssm_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ssm_pkg::ST_IDLE;
                end
            end
            default:               state_next = ssm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory addresses, write enables and the issue tag
    always_comb
    begin
        tag0       = '0;
        coef_raddr = '0;
        x_raddr    = '0;
        issue_done = 1'b0;
        coef_we    = 1'b0;
        coef_waddr = '0;
        x_we       = (state_reg == ssm_pkg::ST_WRITEBACK);

        if (state_reg == ssm_pkg::ST_CWRITE)
        begin
            if (int'(row_reg) < ssm_pkg::MAX_STATES)
            begin
                case (kind_reg)
                    ssm_pkg::KIND_A:
                    begin
                        coef_we    = (int'(col_reg) < ssm_pkg::MAX_STATES);
                        coef_waddr = AW'(row_reg) * AW'(ssm_pkg::MAX_STATES) + AW'(col_reg);
                    end
                    ssm_pkg::KIND_B:
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = AW'(ssm_pkg::B_BASE) + AW'(row_reg);
                    end
                    ssm_pkg::KIND_C:
                    begin
                        coef_we    = 1'b1;
                        coef_waddr = AW'(ssm_pkg::C_BASE) + AW'(row_reg);
                    end
                    default:
                    begin
                        coef_we = 1'b0;
                    end
                endcase
            end
        end

        if (state_reg == ssm_pkg::ST_ISSUE)
        begin
            tag0.valid = 1'b1;
            tag0.op    = op_reg;
            tag0.row   = i_idx;
            case (op_reg)
                ssm_pkg::OP_STEP:
                begin
                    tag0.use_u = (j_reg == n_reg);
                    tag0.first = (j_reg == '0);
                    tag0.last  = tag0.use_u;
                    coef_raddr = tag0.use_u ? AW'(ssm_pkg::B_BASE) + AW'(i_idx)
                               : AW'(i_idx) * AW'(ssm_pkg::MAX_STATES) + AW'(j_idx);
                    x_raddr    = j_idx;
                    issue_done = (i_reg == n_reg - CW'(1)) && tag0.use_u;
                end
                ssm_pkg::OP_COPY:
                begin
                    coef_raddr = AW'(ssm_pkg::B_BASE) + AW'(i_idx);
                    issue_done = (i_reg == n_reg - CW'(1));
                end
                default:
                begin
                    tag0.first = (i_reg == '0);
                    tag0.last  = (i_reg == n_reg - CW'(1));
                    coef_raddr = AW'(ssm_pkg::C_BASE) + AW'(i_idx);
                    x_raddr    = i_idx;
                    issue_done = tag0.last;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Item registers, operation and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= ssm_pkg::OP_OUT;
            n_reg  <= CW'(1);
            i_reg  <= '0;
            j_reg  <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                n_reg <= n_clamp;
                i_reg <= '0;
                j_reg <= '0;
                case (ssm_pkg::cmd_t'(s_axis_tuser[1:0]))
                    ssm_pkg::CMD_STEP: op_reg <= ssm_pkg::OP_STEP;
                    ssm_pkg::CMD_COPY: op_reg <= ssm_pkg::OP_COPY;
                    default:           op_reg <= ssm_pkg::OP_OUT;
                endcase
            end
            else if (state_reg == ssm_pkg::ST_ISSUE)
            begin
                if (issue_done)
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                else if ((op_reg == ssm_pkg::OP_STEP) && (j_reg != n_reg))
                begin
                    j_reg <= j_reg + CW'(1);
                end
                else
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + CW'(1);
                end
            end
            else if (state_reg == ssm_pkg::ST_WRITEBACK)
            begin
                if (wb_done)
                begin
                    i_reg  <= '0;
                    op_reg <= ssm_pkg::OP_OUT;
                end
                else
                begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            else if (state_reg == ssm_pkg::ST_CWRITE)
            begin
                op_reg <= ssm_pkg::OP_OUT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            value_reg <= s_axis_tdata[31:0];
            row_reg   <= s_axis_tdata[33:32];
            col_reg   <= s_axis_tdata[35:34];
            kind_reg  <= s_axis_tuser[3:2];
        end
    end

    // Coefficient memory: A rows, then B, then C
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= value_reg;
        end
        coef_q_reg <= coef_mem[coef_raddr];
    end

    // State memory; an entry never written since reset reads as zero
    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[i_idx] <= next_x_reg[i_idx];
        end
        x_q_reg <= x_mem[x_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= '0;
            x_qv_reg    <= 1'b0;
        end
        else
        begin
            if (x_we)
            begin
                x_valid_reg[i_idx] <= 1'b1;
            end
            x_qv_reg <= x_valid_reg[x_raddr];
        end
    end

    // Multiply-accumulate pipeline
    assign x_rd    = x_qv_reg ? x_q_reg : '0;
    assign mul_a   = coef_q_reg;
    assign mul_b   = tag1_reg.use_u ? value_reg : x_rd;
    assign term    = ssm_pkg::ACC_W'(prod_reg >>> ssm_pkg::FRAC_BITS);
    assign acc_sum = (tag2_reg.first ? '0 : acc_reg) + term;
    assign sat_res = ssm_pkg::saturate(acc_sum);

    // A copy of B bypasses the accumulator.
    always_comb
    begin
        tag1_mac = tag1_reg;
        if (tag1_reg.op == ssm_pkg::OP_COPY)
        begin
            tag1_mac.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_mac;
            if (in_accept)
            begin
                flag_reg <= 1'b0;
            end
            else if (tag2_reg.valid && tag2_reg.last && sat_res.clip)
            begin
                flag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (tag2_reg.valid)
        begin
            acc_reg <= acc_sum;
            if (tag2_reg.last && (tag2_reg.op == ssm_pkg::OP_OUT))
            begin
                y_res_reg <= sat_res.val;
            end
        end
    end

    // New state values, collected before write-back
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ssm_pkg::MAX_STATES; k++)
        begin
            if (in_accept)
            begin
                next_x_reg[k] <= s_axis_tdata[31:0];
            end
            else if (tag1_reg.valid && (tag1_reg.op == ssm_pkg::OP_COPY)
                     && (tag1_reg.row == IW'(k)))
            begin
                next_x_reg[k] <= coef_q_reg;
            end
            else if (tag2_reg.valid && tag2_reg.last && (tag2_reg.op == ssm_pkg::OP_STEP)
                     && (tag2_reg.row == IW'(k)))
            begin
                next_x_reg[k] <= sat_res.val;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            y_out_reg   <= y_res_reg;
            sat_out_reg <= flag_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = y_out_reg;
    assign m_axis_tuser  = sat_out_reg;

    `include "state_space_model_step_top_assert.svh"

    `SSM_ASSERT_NOW(a_mac_in_window, tag2_reg.valid, mac_window)
    `SSM_ASSERT_NOW(a_wb_after_drain, x_we, !tag1_reg.valid && !tag2_reg.valid)
    `SSM_ASSERT_NOW(a_issue_in_range, state_reg == ssm_pkg::ST_ISSUE, i_reg < n_reg)
    `SSM_ASSERT_NEXT(a_accept_clears_flag, s_axis_tvalid && s_axis_tready, !flag_reg)

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [ssm_pkg::APB_AW-1:0] ADDR_STATES_IN_USE =
        ssm_pkg::APB_AW'(4 * ssm_pkg::REG_STATES_IN_USE);
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        ssm_pkg::cmd_t      cmd;
        logic signed [31:0] value;
        logic [1:0]         kind;
        logic [1:0]         row;
        logic [1:0]         col;
    } ssm_item_t;

    typedef struct {
        logic [31:0] y;
        logic        sat;
    } out_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ssm_pkg::APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ssm_item_t   input_backlog[$];
    out_beat_t   expected_outputs[$];
    ssm_item_t   bus_item;
    ssm_item_t   next_item;
    out_beat_t   oldest_output;
    logic        beat_taken;
    int          gap_left;
    int          burst_left;
    int          ready_pct;
    int          ready_hold;
    int          mismatch_count;

    logic signed [31:0] mat_a [ssm_pkg::MAX_STATES * ssm_pkg::MAX_STATES];
    logic signed [31:0] vec_b [ssm_pkg::MAX_STATES];
    logic signed [31:0] vec_c [ssm_pkg::MAX_STATES];
    logic signed [31:0] state_x [ssm_pkg::MAX_STATES];
    logic [2:0]         cfg_states;

    state_space_model_step_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 clk = ~clk;

    function automatic logic signed [63:0] q_product(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = a;
        wb = b;
        return (wa * wb) >>> ssm_pkg::FRAC_BITS;
    endfunction

    function automatic logic [31:0] clamp_word(input logic signed [63:0] v, output logic hit);
        hit = 1'b1;
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        hit = 1'b0;
        return v[31:0];
    endfunction

    function automatic out_beat_t advance_model(input ssm_item_t it);
        logic signed [63:0] acc;
        logic signed [31:0] next_x [ssm_pkg::MAX_STATES];
        logic               hit;
        logic               clipped;
        int                 n;
        int                 i;
        int                 j;
        out_beat_t          r;
        if (cfg_states == 0)
            n = 1;
        else if (cfg_states > ssm_pkg::MAX_STATES)
            n = ssm_pkg::MAX_STATES;
        else
            n = int'(cfg_states);
        clipped = 1'b0;
        case (it.cmd)
            ssm_pkg::CMD_STEP:
            begin
                for (i = 0; i < n; i++)
                begin
                    acc = q_product(vec_b[i], it.value);
                    for (j = 0; j < n; j++)
                        acc += q_product(mat_a[i * ssm_pkg::MAX_STATES + j], state_x[j]);
                    next_x[i] = clamp_word(acc, hit);
                    clipped |= hit;
                end
                for (i = 0; i < n; i++)
                    state_x[i] = next_x[i];
            end
            ssm_pkg::CMD_SET:
            begin
                for (i = 0; i < n; i++)
                    state_x[i] = it.value;
            end
            ssm_pkg::CMD_COPY:
            begin
                for (i = 0; i < n; i++)
                    state_x[i] = vec_b[i];
            end
            default:
            begin
                case (it.kind)
                    ssm_pkg::KIND_A: mat_a[it.row * ssm_pkg::MAX_STATES + it.col] = it.value;
                    ssm_pkg::KIND_B: vec_b[it.row] = it.value;
                    ssm_pkg::KIND_C: vec_c[it.row] = it.value;
                    default: ;
                endcase
            end
        endcase
        acc = 0;
        for (i = 0; i < n; i++)
            acc += q_product(vec_c[i], state_x[i]);
        r.y   = clamp_word(acc, hit);
        r.sat = clipped | hit;
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            1, 2: return $urandom;
            default: return 32'($urandom_range(0, 262143)) - 32'd131072;
        endcase
    endfunction

    task automatic queue_item(input ssm_pkg::cmd_t cmd, input logic [31:0] value,
                              input logic [1:0] kind, input logic [1:0] row,
                              input logic [1:0] col);
        ssm_item_t it;
        it.cmd   = cmd;
        it.value = value;
        it.kind  = kind;
        it.row   = row;
        it.col   = col;
        input_backlog.push_back(it);
    endtask

    task automatic write_states_in_use(input logic [2:0] count);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_STATES_IN_USE;
        pwdata  <= {29'd0, count};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_states = count;
    endtask

    task automatic wait_drained();
        while (input_backlog.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input out_beat_t want,
                                 input logic [31:0] got_y, input logic got_sat);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected y=%h sat=%b, got y=%h sat=%b",
                     $realtime, what, want.y, want.sat, got_y, got_sat);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || beat_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (input_backlog.size() != 0)
            begin
                next_item = input_backlog.pop_front();
                bus_item      <= next_item;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'd0, next_item.col, next_item.row, next_item.value};
                s_axis_tuser  <= {next_item.kind, next_item.cmd};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the share of ready cycles is redrawn each time a random hold count runs out.
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0, 1: ready_pct <= 100;
                2: ready_pct <= 60;
                default: ready_pct <= 25;
            endcase
            ready_hold <= $urandom_range(20, 120);
        end
        else
        begin
            ready_hold <= ready_hold - 1;
        end
        m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    oldest_output.y   = 'x;
                    oldest_output.sat = 1'bx;
                    note_mismatch("unexpected beat", oldest_output, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    oldest_output = expected_outputs.pop_front();
                    if (m_axis_tdata !== oldest_output.y || m_axis_tuser !== oldest_output.sat)
                        note_mismatch("output mismatch", oldest_output, m_axis_tdata,
                                      m_axis_tuser);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_outputs.push_back(advance_model(bus_item));
        end
        beat_taken <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    initial
    begin
        #20_000_000;
        $display("state_space_model_step_top test failed");
        $finish;
    end

    initial
    begin
        logic [2:0]    phase_counts [9];
        logic [31:0]   v;
        ssm_pkg::cmd_t c;
        int            p;
        int            k;
        int            r;
        int            q;
        phase_counts = '{3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd5, 3'd7, 3'd6, 3'd4};
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        beat_taken     = 1'b0;
        gap_left       = 0;
        burst_left     = 0;
        ready_pct      = 100;
        ready_hold     = 0;
        mismatch_count = 0;
        cfg_states     = 3'(ssm_pkg::CFG_N_RESET);
        for (k = 0; k < ssm_pkg::MAX_STATES; k++)
            state_x[k] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every item reads C over the used elements, so C[0] is loaded first with one
        // element in use, and all other coefficients before anything else reads them.
        write_states_in_use(3'd1);
        queue_item(ssm_pkg::CMD_COEF, random_word(), ssm_pkg::KIND_C, 2'd0, 2'd0);
        for (r = 0; r < ssm_pkg::MAX_STATES; r++)
            for (q = 0; q < ssm_pkg::MAX_STATES; q++)
                queue_item(ssm_pkg::CMD_COEF, 32'($urandom_range(0, 65535)) - 32'd32768,
                           ssm_pkg::KIND_A, 2'(r), 2'(q));
        for (r = 0; r < ssm_pkg::MAX_STATES; r++)
            queue_item(ssm_pkg::CMD_COEF, random_word(), ssm_pkg::KIND_B, 2'(r), 2'd0);
        for (r = 1; r < ssm_pkg::MAX_STATES; r++)
            queue_item(ssm_pkg::CMD_COEF, random_word(), ssm_pkg::KIND_C, 2'(r), 2'd0);
        wait_drained();

        write_states_in_use(3'd4);
        queue_item(ssm_pkg::CMD_SET,  32'h7fff_ffff, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_STEP, 32'h7fff_ffff, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_SET,  32'h8000_0000, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_STEP, 32'h8000_0000, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_COPY, 32'h0000_0000, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_STEP, 32'h0000_0000, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_COEF, 32'h1234_5678, 2'd3, 2'd3, 2'd3);
        queue_item(ssm_pkg::CMD_COEF, 32'h7fff_ffff, ssm_pkg::KIND_A, 2'd3, 2'd3);
        queue_item(ssm_pkg::CMD_COEF, 32'h7fff_ffff, ssm_pkg::KIND_C, 2'd3, 2'd0);
        queue_item(ssm_pkg::CMD_SET,  32'h7fff_ffff, 2'd3, 2'd3, 2'd3);
        queue_item(ssm_pkg::CMD_STEP, 32'hffff_ffff, 2'd3, 2'd3, 2'd3);
        queue_item(ssm_pkg::CMD_COEF, 32'h8000_0000, ssm_pkg::KIND_B, 2'd0, 2'd3);
        queue_item(ssm_pkg::CMD_COPY, 32'hffff_ffff, 2'd2, 2'd1, 2'd2);
        queue_item(ssm_pkg::CMD_STEP, 32'h8000_0000, 2'd1, 2'd2, 2'd1);
        queue_item(ssm_pkg::CMD_COEF, 32'hffff_ffff, ssm_pkg::KIND_A, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_COEF, 32'h0000_8000, ssm_pkg::KIND_C, 2'd3, 2'd0);
        queue_item(ssm_pkg::CMD_SET,  32'hffff_0000, 2'd0, 2'd0, 2'd0);
        queue_item(ssm_pkg::CMD_STEP, 32'h0001_0000, 2'd0, 2'd0, 2'd0);
        wait_drained();

        // Writes beyond the used count are stored and show up once the count grows.
        write_states_in_use(3'd2);
        queue_item(ssm_pkg::CMD_COEF, 32'h0002_0000, ssm_pkg::KIND_B, 2'd3, 2'd0);
        queue_item(ssm_pkg::CMD_COEF, 32'h0000_4000, ssm_pkg::KIND_A, 2'd3, 2'd2);
        queue_item(ssm_pkg::CMD_STEP, 32'h0001_0000, 2'd0, 2'd0, 2'd0);
        wait_drained();
        write_states_in_use(3'd4);
        queue_item(ssm_pkg::CMD_STEP, 32'h0001_0000, 2'd0, 2'd0, 2'd0);
        wait_drained();

        for (p = 0; p < 9; p++)
        begin
            write_states_in_use(phase_counts[p]);
            for (k = 0; k < 112; k++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9: c = ssm_pkg::CMD_STEP;
                    10, 11, 12: c = ssm_pkg::CMD_SET;
                    13, 14: c = ssm_pkg::CMD_COPY;
                    default: c = ssm_pkg::CMD_COEF;
                endcase
                v = random_word();
                r = $urandom_range(0, 3);
                if (c == ssm_pkg::CMD_COEF && r == ssm_pkg::KIND_A && $urandom_range(0, 4) != 0)
                    v = 32'($urandom_range(0, 65535)) - 32'd32768;
                queue_item(c, v, 2'(r), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end
            wait_drained();
        end

        if (mismatch_count == 0 && expected_outputs.size() == 0)
            $display("state_space_model_step_top test passed");
        else
            $display("state_space_model_step_top test failed");
        $finish;
    end

endmodule
